// ===== hw/rtl/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [VAL_W-1:0]  value;
  } rsp_t;

endpackage

// ===== hw/rtl/lkv_if.sv =====
// ----------------------------------------------------------------------------
// lkv_if
// Request and response channel interfaces for the LRU key-value cache.
// ----------------------------------------------------------------------------
interface lkv_in_if;
  logic                              valid;
  logic                              ready;
  lkv_pkg::action_t                  action;
  logic signed [lkv_pkg::KEY_W-1:0]  lookup_key;
  logic signed [lkv_pkg::VAL_W-1:0]  write_value;

  modport source (output valid, output action, output lookup_key, output write_value,
                  input ready);
  modport sink   (input valid, input action, input lookup_key, input write_value,
                  output ready);
endinterface

interface lkv_out_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic signed [lkv_pkg::VAL_W-1:0]  read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ===== hw/rtl/lkv_store.sv =====
// ----------------------------------------------------------------------------
// lkv_store
// Fully associative entry array with recency ranks: parallel key match,
// victim and free slot selection, and a registered update for each item.
// ----------------------------------------------------------------------------
module lkv_store #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_fire,
  input  lkv_pkg::req_t              req,
  input  logic [lkv_pkg::CAP_W-1:0]  cap,
  output lkv_pkg::rsp_t              rsp
);

  localparam int IDX_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RANK_W    = IDX_W;
  localparam int OCC_W     = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_CMP_W = (OCC_W > lkv_pkg::CAP_W) ? OCC_W : lkv_pkg::CAP_W;

  logic [MAX_ENTRIES-1:0]    valid_r;
  logic [lkv_pkg::KEY_W-1:0] key_r   [MAX_ENTRIES];
  logic [lkv_pkg::VAL_W-1:0] value_r [MAX_ENTRIES];
  logic [RANK_W-1:0]         rank_r  [MAX_ENTRIES];
  logic [OCC_W-1:0]          occ_r;

  logic [MAX_ENTRIES-1:0]    match;
  logic [MAX_ENTRIES-1:0]    oldest;
  logic                      any_hit;
  logic                      any_free;
  logic [IDX_W-1:0]          hit_idx;
  logic [IDX_W-1:0]          victim_idx;
  logic [IDX_W-1:0]          free_idx;
  logic [IDX_W-1:0]          tgt_idx;
  logic [RANK_W-1:0]         tgt_rank;
  logic [CAP_CMP_W-1:0]      eff_cap;
  logic                      full;
  logic                      is_put;
  logic [OCC_W-1:0]          occ_m1;

  // per-entry compare and lowest-index pick
  always_comb begin
    occ_m1     = occ_r - OCC_W'(1);
    any_hit    = 1'b0;
    any_free   = 1'b0;
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == req.key);
      oldest[i] = valid_r[i] && (OCC_W'(rank_r[i]) == occ_m1);
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        any_hit = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (oldest[i]) begin
        victim_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // effective capacity, clamped to 1 .. MAX_ENTRIES
  always_comb begin
    eff_cap = CAP_CMP_W'(cap);
    if (cap == '0) begin
      eff_cap = CAP_CMP_W'(1);
    end else if (eff_cap > CAP_CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CAP_CMP_W'(MAX_ENTRIES);
    end
    full = (CAP_CMP_W'(occ_r) >= eff_cap) || !any_free;
  end

  assign is_put   = (req.action == lkv_pkg::ACT_PUT);
  assign tgt_idx  = any_hit ? hit_idx : (full ? victim_idx : free_idx);
  assign tgt_rank = rank_r[tgt_idx];

  assign rsp.hit   = any_hit;
  assign rsp.value = any_hit ? value_r[hit_idx] : lkv_pkg::MISS_VALUE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else if (req_fire && is_put && !any_hit) begin
      valid_r[tgt_idx] <= 1'b1;
      if (!full) begin
        occ_r <= occ_r + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && (any_hit || is_put)) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IDX_W'(i) != tgt_idx && valid_r[i] &&
            (!any_hit || (rank_r[i] < tgt_rank))) begin
          rank_r[i] <= rank_r[i] + 1'b1;
        end
      end
      rank_r[tgt_idx] <= '0;
      if (is_put) begin
        value_r[tgt_idx] <= req.value;
      end
      if (is_put && !any_hit) begin
        key_r[tgt_idx] <= req.key;
      end
    end
  end

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Key-value cache with least-recently-used replacement. A get returns the
// stored value or a miss; a put inserts or updates and returns nothing.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    action, lookup_key, write_value
//   out_ch   out  valid/ready    hit, read_value
//   cfg      in   cfg_we         cfg_wdata (capacity_limit)
//
// One item per cycle unless stalled: an item is held in the input register while
// the entry array resolves it, and the array updates when the item moves on.
// A get result passes from the input register to the output register. Input
// stalls only when a get waits on a full output register. Reset clears valid
// bits, occupancy and handshake state; capacity resets to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  lkv_in_if.sink                     in_ch,
  lkv_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]  cfg_wdata
);

  logic                      in_valid_r;
  lkv_pkg::req_t             in_req_r;
  logic                      out_valid_r;
  lkv_pkg::rsp_t             out_rsp_r;
  logic [lkv_pkg::CAP_W-1:0] cap_r;

  lkv_pkg::rsp_t             store_rsp;
  logic                      is_get;
  logic                      proceed;
  logic                      in_fire;

  assign is_get  = (in_req_r.action == lkv_pkg::ACT_GET);
  assign proceed = in_valid_r && (!is_get || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || proceed;
  assign in_fire = in_ch.valid && in_ch.ready;

  lkv_store #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_fire (proceed),
    .req      (in_req_r),
    .cap      (cap_r),
    .rsp      (store_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= lkv_pkg::CAP_RESET;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (proceed && is_get) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_req_r.action <= in_ch.action;
      in_req_r.key    <= in_ch.lookup_key;
      in_req_r.value  <= in_ch.write_value;
    end
    if (proceed && is_get) begin
      out_rsp_r <= store_rsp;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_rsp_r.hit;
  assign out_ch.read_value = out_rsp_r.value;

endmodule

// ===== bench/tb_lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Drives gets and puts into the LRU cache with bursty input and a patterned
// output stall. An in-bench model of the entry array predicts each get result
// unless a directed row gives it, and each returned item is compared field by field in order.
// Capacity is rewritten between phases, including below current occupancy.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;

  localparam int SLOTS      = 16;
  localparam int STUCK_MAX  = 1500;
  localparam int PHASES     = 13;
  localparam int PHASE_LEN  = 145;
  localparam int ROWS       = 24;
  localparam int CAP_BITS   = lkv_pkg::CAP_W;

  typedef struct packed {
    bit                  set_cap;
    logic [CAP_BITS-1:0] cap;
    lkv_pkg::action_t    act;
    logic [31:0]         key;
    logic [31:0]         val;
    bit                  typed;
    bit                  hit;
    logic [31:0]         rd;
  } script_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CAP_BITS-1:0] cfg_wdata;

  lkv_in_if  in_ch ();
  lkv_out_if out_ch ();

  lru_key_value_cache dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the entry array
  bit                  slot_valid [SLOTS];
  logic [31:0]         slot_key   [SLOTS];
  logic [31:0]         slot_val   [SLOTS];
  int unsigned         slot_rank  [SLOTS];
  int unsigned         fill_count;
  logic [CAP_BITS-1:0] capacity_reg;

  lkv_pkg::rsp_t pending_rsp [$];
  lkv_pkg::rsp_t oldest_rsp;
  int          error_count;
  int          stuck_cycles;
  int          items_sent, gets_sent, hits_seen, evictions, results_checked, cap_writes;

  logic [31:0] key_pool [32];
  int          pool_n;
  int          put_pct;
  int          gap_max;
  logic [15:0] stall_mask;
  logic [3:0]  stall_phase;
  bit          hold_req;
  int          hold_len;

  script_row_t directed_rows [ROWS] = '{
    '{1'b0, 5'd0,  lkv_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0,
      lkv_pkg::MISS_VALUE},
    '{1'b0, 5'd0,  lkv_pkg::ACT_GET, 32'h8000_0000, 32'h1234_5678, 1'b1, 1'b0,
      lkv_pkg::MISS_VALUE},
    '{1'b0, 5'd0,  lkv_pkg::ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  lkv_pkg::ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  lkv_pkg::ACT_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  lkv_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  lkv_pkg::ACT_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{1'b0, 5'd0,  lkv_pkg::ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{1'b0, 5'd0,  lkv_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{1'b0, 5'd0,  lkv_pkg::ACT_PUT, 32'h0000_0000, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  lkv_pkg::ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h5A5A_5A5A},
    '{1'b0, 5'd0,  lkv_pkg::ACT_GET, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b0,
      lkv_pkg::MISS_VALUE},
    '{1'b1, 5'd0,  lkv_pkg::ACT_GET, 32'h0,         32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  lkv_pkg::ACT_PUT, 32'h0000_0005, 32'h0000_0055, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  lkv_pkg::ACT_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  lkv_pkg::ACT_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  lkv_pkg::ACT_PUT, 32'h0000_0006, 32'h0000_0066, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  lkv_pkg::ACT_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b1, 5'd31, lkv_pkg::ACT_GET, 32'h0,         32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  lkv_pkg::ACT_PUT, 32'h0000_0007, 32'h0000_0077, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  lkv_pkg::ACT_GET, 32'h0000_0006, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b1, 5'd1,  lkv_pkg::ACT_GET, 32'h0,         32'h0,         1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  lkv_pkg::ACT_PUT, 32'h0000_0008, 32'h0000_0088, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  lkv_pkg::ACT_GET, 32'h0000_0007, 32'h0000_0000, 1'b0, 1'b0, 32'h0}
  };

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void make_recent(int s, int unsigned lim);
    for (int i = 0; i < SLOTS; i++) begin
      if (i != s && slot_valid[i] && slot_rank[i] < lim) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  // applies one request to the shadow array; returns 1 when a result is due
  function automatic bit cache_access(input lkv_pkg::action_t act, input logic [31:0] key,
                                      input logic [31:0] val, output lkv_pkg::rsp_t rsp);
    int          s;
    int unsigned eff;
    rsp = '0;
    s = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_key[i] == key) s = i;
    end
    if (act == lkv_pkg::ACT_GET) begin
      if (s >= 0) begin
        make_recent(s, slot_rank[s]);
        rsp.hit   = 1'b1;
        rsp.value = slot_val[s];
      end else begin
        rsp.hit   = 1'b0;
        rsp.value = lkv_pkg::MISS_VALUE;
      end
      return 1'b1;
    end
    if (s >= 0) begin
      slot_val[s] = val;
      make_recent(s, slot_rank[s]);
      return 1'b0;
    end
    eff = (capacity_reg == 0) ? 1 : (capacity_reg > SLOTS) ? SLOTS : capacity_reg;
    if (fill_count >= eff) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && (s < 0 || slot_rank[i] > slot_rank[s])) s = i;
      end
      evictions++;
    end else begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!slot_valid[i]) s = i;
      end
      slot_valid[s] = 1'b1;
      fill_count++;
    end
    make_recent(s, 32'hFFFF_FFFF);
    slot_key[s] = key;
    slot_val[s] = val;
    return 1'b0;
  endfunction

  task automatic send_item(input lkv_pkg::action_t act, input logic [31:0] key,
                           input logic [31:0] val,
                           input bit typed, input bit hit_t, input logic [31:0] rd_t);
    lkv_pkg::rsp_t predicted;
    bit            gives;
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.lookup_key  <= key;
    in_ch.write_value <= val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    gives = cache_access(act, key, val, predicted);
    items_sent++;
    if (gives) begin
      if (typed) begin
        predicted.hit   = hit_t;
        predicted.value = rd_t;
      end
      gets_sent++;
      hits_seen += predicted.hit;
      pending_rsp.push_back(predicted);
    end
  endtask

  task automatic idle(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we       <= 1'b0;
    capacity_reg  = cap;
    cap_writes++;
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, pool_n - 1)];
    return $urandom;
  endfunction

  task automatic send_random();
    lkv_pkg::action_t act;
    act = ($urandom_range(0, 99) < put_pct) ? lkv_pkg::ACT_PUT : lkv_pkg::ACT_GET;
    send_item(act, pick_key(), $urandom, 1'b0, 1'b0, 32'h0);
  endtask

  // receiver: per-phase stall pattern, or one long hold-off on request
  always begin
    @(posedge clk);
    if (hold_req) begin
      out_ch.ready <= 1'b0;
      repeat (hold_len) @(posedge clk);
      hold_req = 1'b0;
    end else begin
      out_ch.ready <= !stall_mask[stall_phase];
      stall_phase  <= stall_phase + 4'd1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_checked++;
      if (pending_rsp.size() == 0) begin
        error_count++;
        if (error_count < 200)
          $display("%0t: unexpected item, expected none, actual hit=%0b read_value=%h",
                   $time, out_ch.hit, out_ch.read_value);
      end else begin
        oldest_rsp = pending_rsp.pop_front();
        if (out_ch.hit !== oldest_rsp.hit) begin
          error_count++;
          if (error_count < 200)
            $display("%0t: hit mismatch, expected %0b actual %0b",
                     $time, oldest_rsp.hit, out_ch.hit);
        end
        if (out_ch.read_value !== oldest_rsp.value) begin
          error_count++;
          if (error_count < 200)
            $display("%0t: read_value mismatch, expected %h actual %h",
                     $time, oldest_rsp.value, out_ch.read_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_MAX) begin
      $display("%0t: no item moved for %0d cycles, %0d results outstanding",
               $time, STUCK_MAX, pending_rsp.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [CAP_BITS-1:0] phase_caps [PHASES];
    int                  burst_left;
    int                  gap;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.action      = lkv_pkg::ACT_GET;
    in_ch.lookup_key  = '0;
    in_ch.write_value = '0;
    out_ch.ready      = 1'b0;
    stall_mask        = '0;
    stall_phase       = '0;
    hold_req          = 1'b0;
    hold_len          = 0;
    error_count       = 0;
    stuck_cycles      = 0;
    items_sent        = 0;
    gets_sent         = 0;
    hits_seen         = 0;
    evictions         = 0;
    results_checked   = 0;
    cap_writes        = 0;
    fill_count        = 0;
    capacity_reg      = lkv_pkg::CAP_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_val[i]   = '0;
      slot_rank[i]  = 0;
    end
    phase_caps = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd8, 5'd0, 5'd4, 5'd15, 5'd17, 5'd3, 5'd16,
                   5'd0, 5'd12};
    phase_caps[11] = CAP_BITS'($urandom_range(0, 31));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].set_cap)
        write_capacity(directed_rows[r].cap);
      else
        send_item(directed_rows[r].act, directed_rows[r].key, directed_rows[r].val,
                  directed_rows[r].typed, directed_rows[r].hit, directed_rows[r].rd);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      pool_n  = $urandom_range(2, 32);
      put_pct = (p % 3 == 0) ? 50 : $urandom_range(25, 75);
      gap_max = (p % 4 == 0) ? 0 : $urandom_range(1, 8);
      if (p % 3 == 0)
        stall_mask = '0;
      else
        stall_mask = 16'($urandom) & ~(16'h1 << $urandom_range(0, 15));
      for (int i = 0; i < 32; i++) begin
        case ($urandom_range(0, 3))
          0: key_pool[i] = i;
          1: key_pool[i] = $urandom;
          2: key_pool[i] = 32'h8000_0000 ^ i;
          default: key_pool[i] = 32'hFFFF_FFFF - i;
        endcase
      end

      if (p == 3) begin
        hold_len = 150;
        hold_req = 1'b1;
        put_pct  = 20;
        repeat (40) send_random();
        drain();
        put_pct  = 50;
      end

      burst_left = 0;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (burst_left == 0) begin
          gap = $urandom_range(0, gap_max);
          if (gap > 0) idle(gap);
          burst_left = $urandom_range(1, 12);
        end
        send_random();
        burst_left--;
      end
    end

    drain();
    repeat (8) @(posedge clk);

    $display("ran %0d items: %0d gets (%0d hits), %0d puts, %0d evictions",
             items_sent, gets_sent, hits_seen, items_sent - gets_sent, evictions);
    $display("checked %0d results over %0d capacity settings", results_checked, cap_writes);
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
